// File: rtl/stc_pkg.sv
package stc_pkg;

   // field and intermediate widths
   localparam int RAW_W      = 16;
   localparam int CAL_W      = 16;
   localparam int DIFF_W     = 17;   // raw - ac6
   localparam int PROD_W     = 33;   // (raw - ac6) * ac5
   localparam int X1_SHIFT   = 15;
   localparam int X1_W       = PROD_W - X1_SHIFT;
   localparam int DEN_W      = X1_W + 1;   // x1 + md
   localparam int MAG_W      = DEN_W - 1;  // |x1 + md| stays below 2^18
   localparam int MC_SHIFT   = 11;
   localparam int NUM_W      = CAL_W + MC_SHIFT;
   localparam int B5_W       = 28;
   localparam int TEMP_W     = 24;
   localparam int TEMP_SHIFT = 4;
   localparam int ROUND      = 8;

   // default quotient bits resolved per divider stage
   localparam int DIV_BITS   = 3;

   localparam int CSR_IDX_W  = 2;

   localparam logic [CAL_W-1:0] AC5_RESET = 16'h7FF5;   // 32757
   localparam logic [CAL_W-1:0] AC6_RESET = 16'h5A71;   // 23153
   localparam logic [CAL_W-1:0] MC_RESET  = 16'hDDF9;   // -8711
   localparam logic [CAL_W-1:0] MD_RESET  = 16'h0B34;   // 2868

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AC5 = 2'd0,
      CSR_AC6 = 2'd1,
      CSR_MC  = 2'd2,
      CSR_MD  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [CAL_W-1:0] ac5;
      logic [CAL_W-1:0] ac6;
      logic [CAL_W-1:0] mc;
      logic [CAL_W-1:0] md;
   } cal_type;

   // word carried through the divider stages
   typedef struct packed {
      logic [X1_W-1:0]  x1;
      logic [MAG_W-1:0] den_mag;
      logic [MAG_W-1:0] rem;
      logic [NUM_W-1:0] quo;     // numerator shifts out, quotient shifts in
      logic             q_neg;
      logic             fault;
   } div_word_type;

endpackage

// File: rtl/stc_front.sv
module stc_front
   import stc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cal_type          cal,
   input  logic             in_valid,
   input  logic [RAW_W-1:0] in_raw,
   output logic             take,
   output logic             out_valid,
   output div_word_type     out_word,
   input  logic             adv
);

   logic                    a_valid_ff, b_valid_ff, c_valid_ff;
   logic                    en_a, en_b, en_c;
   logic [DIFF_W-1:0]       diff_ff, diff_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [2*DIFF_W-1:0] prod_full;
   div_word_type            word_ff, word_in;
   logic [X1_W-1:0]         x1;
   logic [DEN_W-1:0]        den, den_abs;
   logic                    den_neg, mc_neg;
   logic [CAL_W-1:0]        mc_abs;

   // a stage loads when empty or when its contents move on
   assign en_c = !c_valid_ff || adv;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;
   assign take = en_a;

   // offset correction
   assign diff_in = DIFF_W'({1'b0, in_raw}) - DIFF_W'({1'b0, cal.ac6});

   // gain
   assign prod_full = $signed(diff_ff) * $signed({1'b0, cal.ac5});
   assign prod_in   = prod_full[PROD_W-1:0];

   // x1 and divider operands
   always_comb begin
      x1      = prod_ff[PROD_W-1:X1_SHIFT];
      den     = {x1[X1_W-1], x1} + {{(DEN_W-CAL_W){cal.md[CAL_W-1]}}, cal.md};
      den_neg = den[DEN_W-1];
      den_abs = den_neg ? (~den + DEN_W'(1)) : den;
      mc_neg  = cal.mc[CAL_W-1];
      mc_abs  = mc_neg ? (~cal.mc + CAL_W'(1)) : cal.mc;
      word_in.x1      = x1;
      word_in.den_mag = den_abs[MAG_W-1:0];
      word_in.rem     = '0;
      word_in.quo     = {mc_abs, {MC_SHIFT{1'b0}}};
      word_in.q_neg   = mc_neg ^ den_neg;
      word_in.fault   = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= in_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) diff_ff <= diff_in;
      if (en_b) prod_ff <= prod_in;
      if (en_c) word_ff <= word_in;
   end

   assign out_valid = c_valid_ff;
   assign out_word  = word_ff;

endmodule

// File: rtl/stc_div_stage.sv
module stc_div_stage
   import stc_pkg::*;
#(
   parameter int STEPS = DIV_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  div_word_type in_word,
   output logic         take,
   output logic         out_valid,
   output div_word_type out_word,
   input  logic         adv
);

   logic         valid_ff;
   div_word_type word_ff, word_in;
   logic [MAG_W:0] trial;

   assign take = !valid_ff || adv;

   // restoring division, STEPS quotient bits
   always_comb begin
      word_in = in_word;
      trial   = '0;
      for (int j = 0; j < STEPS; j++) begin
         trial       = {word_in.rem, word_in.quo[NUM_W-1]};
         word_in.quo = {word_in.quo[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, word_in.den_mag}) begin
            word_in.rem    = MAG_W'(trial - {1'b0, word_in.den_mag});
            word_in.quo[0] = 1'b1;
         end else begin
            word_in.rem = trial[MAG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: rtl/stc_back.sv
module stc_back
   import stc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  div_word_type             in_word,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_temp_tenths,
   output logic signed [B5_W-1:0]   rsp_shared_b5,
   output logic                     rsp_divide_fault
);

   logic              e_valid_ff, rsp_valid_ff;
   logic              en_e, en_out;
   logic [B5_W-1:0]   b5_ff, b5_in, x2, b5_round;
   logic              fault_ff;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic [B5_W-1:0]   b5_out_ff, b5_out_in;
   logic              fault_out_ff;

   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en_e   = !e_valid_ff || en_out;
   assign take   = en_e;

   // signed quotient and b5
   always_comb begin
      x2    = in_word.q_neg ? (~{1'b0, in_word.quo} + B5_W'(1)) : {1'b0, in_word.quo};
      b5_in = {{(B5_W-X1_W){in_word.x1[X1_W-1]}}, in_word.x1} + x2;
   end

   // rounding and zeroing on a bad divisor
   always_comb begin
      b5_round = b5_ff + B5_W'(ROUND);
      if (fault_ff) begin
         temp_in   = '0;
         b5_out_in = '0;
      end else begin
         temp_in   = b5_round[B5_W-1:TEMP_SHIFT];
         b5_out_in = b5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_e)   e_valid_ff   <= in_valid;
         if (en_out) rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         b5_ff    <= b5_in;
         fault_ff <= in_word.fault;
      end
      if (en_out) begin
         temp_ff      <= temp_in;
         b5_out_ff    <= b5_out_in;
         fault_out_ff <= fault_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_tenths  = $signed(temp_ff);
   assign rsp_shared_b5    = $signed(b5_out_ff);
   assign rsp_divide_fault = fault_out_ff;

endmodule

// File: rtl/sensor_temp_compensation_top.sv
// Temperature compensation for a barometric sensor. Each raw 16-bit
// temperature word gives one result word: b5 = x1 + x2 with
// x1 = ((raw - ac6) * ac5) >>> 15 and x2 = (mc << 11) / (x1 + md) truncated
// toward zero, and temp_tenths = (b5 + 8) >>> 4 in 0.1 degree units (software
// does the final divide by ten). A zero divisor sets divide_fault and clears
// both result fields. The block takes one word per clock while req_stall is
// low; a pipelined restoring divider resolves the 27 quotient bits. Three
// front stages hold the offset subtract, the 17x17 multiply and the divisor
// setup; two back stages form b5 and the rounded temperature, the last being
// the output register. The user must write calibration registers through
// the csr port only while no word is in flight; the block does not enforce
// this.
module sensor_temp_compensation_top
   import stc_pkg::*;
#(
   parameter int DIV_BITS_PER_STAGE = DIV_BITS   // 1 to 27
)
(
   input  logic                     clock,
   input  logic                     reset,
   // calibration write port
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CAL_W-1:0]         csr_wdata,
   // raw word in
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [RAW_W-1:0]         req_raw_temperature,
   // compensated word out
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_temp_tenths,
   output logic signed [B5_W-1:0]   rsp_shared_b5,
   output logic                     rsp_divide_fault
);

   localparam int DIV_STAGES = (NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

   cal_type      cal_ff;
   logic         front_take;
   logic         stg_valid [0:DIV_STAGES];
   div_word_type stg_word  [0:DIV_STAGES];
   logic         stg_take  [0:DIV_STAGES];

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.ac5 <= AC5_RESET;
         cal_ff.ac6 <= AC6_RESET;
         cal_ff.mc  <= MC_RESET;
         cal_ff.md  <= MD_RESET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_AC5: cal_ff.ac5 <= csr_wdata;
            CSR_AC6: cal_ff.ac6 <= csr_wdata;
            CSR_MC:  cal_ff.mc  <= csr_wdata;
            CSR_MD:  cal_ff.md  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offset, gain, divisor setup
   stc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (req_valid),
      .in_raw    (req_raw_temperature),
      .take      (front_take),
      .out_valid (stg_valid[0]),
      .out_word  (stg_word[0]),
      .adv       (stg_take[0])
   );

   // back pressure ripples upstream only through full stages
   assign req_stall = !front_take;

   // divider pipeline, last stage may resolve fewer bits
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int LEFT  = NUM_W - s * DIV_BITS_PER_STAGE;
      localparam int STEPS = (LEFT < DIV_BITS_PER_STAGE) ? LEFT : DIV_BITS_PER_STAGE;
      stc_div_stage #(.STEPS(STEPS)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_word   (stg_word[s]),
         .take      (stg_take[s]),
         .out_valid (stg_valid[s+1]),
         .out_word  (stg_word[s+1]),
         .adv       (stg_take[s+1])
      );
   end

   // b5, rounding, output register
   stc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (stg_valid[DIV_STAGES]),
      .in_word          (stg_word[DIV_STAGES]),
      .take             (stg_take[DIV_STAGES]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temp_tenths  (rsp_temp_tenths),
      .rsp_shared_b5    (rsp_shared_b5),
      .rsp_divide_fault (rsp_divide_fault)
   );

endmodule

// File: rtl/stc_checker.sv
module stc_checker
   import stc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [TEMP_W-1:0] rsp_temp_tenths,
   input logic signed [B5_W-1:0]   rsp_shared_b5,
   input logic                     rsp_divide_fault
);

   logic [B5_W-1:0] b5_round;

   assign b5_round = rsp_shared_b5 + B5_W'(ROUND);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a bad divisor gives zero results
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_temp_tenths == '0 && rsp_shared_b5 == '0)
      else $error("divide fault with nonzero results");

   // temperature is the rounded b5
   a_temp_from_b5: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_fault |-> rsp_temp_tenths == b5_round[B5_W-1:TEMP_SHIFT])
      else $error("temperature does not match b5");

   // input side only stalls behind a stalled full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back pressure");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_tenths)
         && $stable(rsp_shared_b5) && $stable(rsp_divide_fault))
      else $error("stalled result word changed");

endmodule

bind sensor_temp_compensation_top stc_checker u_stc_checker (.*);
